>>> src/mcs_pkg.sv
// shared types and constants of the memory-to-memory step unit
// no dependencies; used by the interfaces, the serial alu and the top level
package mcs_pkg;

	localparam int ADDR_BITS = 15;
	localparam int WORD_W    = 16;
	localparam int DIGIT_W   = 4;
	localparam int DIGITS    = WORD_W / DIGIT_W;
	localparam int MEM_WORDS = 1 << ADDR_BITS;
	localparam int FIELD_W   = 12;
	localparam int OPC_W     = 4;
	localparam int KIND_W    = 2;
	localparam int ADDR_IN_W = 15;

	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_STEP  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [OPC_W-1:0] {
		OP_MV  = 4'd0,
		OP_XG  = 4'd1,
		OP_AD  = 4'd2,
		OP_SB  = 4'd3,
		OP_AND = 4'd4,
		OP_OR  = 4'd5,
		OP_XOR = 4'd6,
		OP_SR  = 4'd7,
		OP_SL  = 4'd8,
		OP_SA  = 4'd9,
		OP_MI  = 4'd10,
		OP_MD  = 4'd11,
		OP_JG  = 4'd12,
		OP_JL  = 4'd13,
		OP_JQ  = 4'd14,
		OP_HLT = 4'd15
	} op_t;

	typedef enum logic [2:0] {
		FN_ADD,
		FN_SUB,
		FN_AND,
		FN_OR,
		FN_XOR
	} alu_fn_t;

	typedef struct packed {
		logic    start;
		alu_fn_t fn;
	} alu_ctl_t;

	typedef struct packed {
		logic done;
		logic carry;
		logic eq;
	} alu_sts_t;

endpackage

>>> src/mcs_req_if.sv
// request channel of the step unit: kind, address and write data
// depends on mcs_pkg
interface mcs_req_if;
	import mcs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [ADDR_IN_W-1:0] address;
	logic [WORD_W-1:0]    write_data;

	modport source(output valid, kind, address, write_data, input ready);
	modport sink(input valid, kind, address, write_data, output ready);
endinterface

>>> src/mcs_rsp_if.sv
// response channel of the step unit: read data, halt flag, executed pointer and opcode
// depends on mcs_pkg
interface mcs_rsp_if;
	import mcs_pkg::*;
	logic             valid;
	logic             ready;
	logic [WORD_W-1:0] read_data;
	logic             halted;
	logic [WORD_W-1:0] executed_pointer;
	logic [OPC_W-1:0] executed_opcode;

	modport source(output valid, read_data, halted, executed_pointer, executed_opcode,
		input ready);
	modport sink(input valid, read_data, halted, executed_pointer, executed_opcode,
		output ready);
endinterface

>>> src/mcs_ram.sv
// generic single-port ram with registered read
// no dependencies
module mcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> src/mcs_alu.sv
// nibble-serial alu: add, subtract and logic ops, one digit per cycle
// depends on mcs_pkg
module mcs_alu (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mcs_pkg::alu_ctl_t         ctl,
	input  logic [mcs_pkg::WORD_W-1:0] a,
	input  logic [mcs_pkg::WORD_W-1:0] b,
	output mcs_pkg::alu_sts_t         sts,
	output logic [mcs_pkg::WORD_W-1:0] result
);
	import mcs_pkg::*;

	localparam int CNT_W = $clog2(DIGITS);

	word_t              a_q, b_q, res_q;
	alu_fn_t            fn_q;
	logic               carry_q, eq_q, busy_q, done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIGIT_W-1:0] b_dig, dig;
	logic [DIGIT_W:0]   sum;

	always_comb begin
		b_dig = (fn_q == FN_SUB) ? ~b_q[DIGIT_W-1:0] : b_q[DIGIT_W-1:0];
		sum   = {1'b0, a_q[DIGIT_W-1:0]} + {1'b0, b_dig} + {{DIGIT_W{1'b0}}, carry_q};
		unique case (fn_q)
			FN_AND:  dig = a_q[DIGIT_W-1:0] & b_q[DIGIT_W-1:0];
			FN_OR:   dig = a_q[DIGIT_W-1:0] | b_q[DIGIT_W-1:0];
			FN_XOR:  dig = a_q[DIGIT_W-1:0] ^ b_q[DIGIT_W-1:0];
			default: dig = sum[DIGIT_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIGITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath, low digit first
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q     <= a;
			b_q     <= b;
			fn_q    <= ctl.fn;
			carry_q <= (ctl.fn == FN_SUB);
			eq_q    <= 1'b1;
		end else if (busy_q) begin
			a_q     <= a_q >> DIGIT_W;
			b_q     <= b_q >> DIGIT_W;
			res_q   <= {dig, res_q[WORD_W-1:DIGIT_W]};
			carry_q <= sum[DIGIT_W];
			eq_q    <= eq_q && (a_q[DIGIT_W-1:0] == b_q[DIGIT_W-1:0]);
		end
	end

	assign sts.done  = done_q;
	assign sts.carry = carry_q;
	assign sts.eq    = eq_q;
	assign result    = res_q;
endmodule

>>> src/mem_to_mem_cpu_step_unit.sv
// Memory-to-memory step unit. Requests arrive on req: kind 0 writes address with
// write_data, kind 1 reads address, kind 2 executes one instruction found at the
// pointer held in word 0, kind 3 does nothing. Every request gives exactly one
// response on rsp with read_data, the sticky halted flag, and for a step the
// pointer and opcode of the instruction.
// The word memory has a single port, so every fetch, operand read and write
// uses it in turn; adds, subtracts, logic ops and compares go through the
// nibble-serial alu, and a shift moves its operand one bit at a time.
// One request is in work at a time; req.ready is high in the idle state even
// while a response waits in the output register, so a stalled receiver holds
// at most one finished response and the next request then waits in its final
// state until the output register frees.
// Reset clears the halt flag and the control state. The word memory is not
// cleared: a word must be written before it is read.
module mem_to_mem_cpu_step_unit (
	input logic      clk,
	input logic      arst_n,
	mcs_req_if.sink   req,
	mcs_rsp_if.source rsp
);
	import mcs_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_CAP, ST_F_IP, ST_F_W0,
		ST_J_W1, ST_J_W2, ST_J_A, ST_J_B, ST_J_CMP,
		ST_P_SRC, ST_G_SRC, ST_G_D, ST_G_S, ST_G_DD, ST_X_WR2,
		ST_ALU, ST_SHIFT, ST_DONE
	} state_t;

	state_t             state_q;
	logic               halt_q, out_valid_q;
	word_t              ip_q, w1_q, tgt_q, d_q, acc_q;
	word_t              rd_data_q, eptr_q;
	logic [OPC_W-1:0]   eop_q, op_q;
	logic [FIELD_W-1:0] f_q;
	logic [DIGIT_W-1:0] cnt_q;
	word_t              out_data_q, out_eptr_q;
	logic [OPC_W-1:0]   out_eop_q;
	logic               out_halt_q;

	addr_t    ram_addr;
	logic     ram_we;
	word_t    ram_wdata, ram_rdata, alu_res;
	alu_ctl_t alu_ctl;
	alu_sts_t alu_sts;
	logic     accept, out_free, take;
	logic [OPC_W-1:0] op_in;

	mcs_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_ram (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	mcs_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (alu_ctl),
		.a     (d_q),
		.b     (ram_rdata),
		.sts   (alu_sts),
		.result(alu_res)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign op_in     = ram_rdata[WORD_W-1 -: OPC_W];

	always_comb begin
		unique case (op_q)
			OP_JG:   take = alu_sts.carry && !alu_sts.eq;
			OP_JL:   take = !alu_sts.carry;
			default: take = alu_sts.eq;
		endcase
	end

	// memory port and alu control
	always_comb begin
		ram_addr    = '0;
		ram_we      = 1'b0;
		ram_wdata   = req.write_data;
		alu_ctl.start = 1'b0;
		alu_ctl.fn    = FN_ADD;
		unique case (state_q)
			ST_IDLE: begin
				ram_addr = (req.kind == KIND_STEP) ? '0 : ADDR_BITS'(req.address);
				ram_we   = accept && (req.kind == KIND_WRITE);
			end
			ST_F_IP: ram_addr = ADDR_BITS'(ram_rdata);
			ST_F_W0: begin
				if (!halt_q && op_in < OP_JG) begin
					ram_we    = 1'b1;
					ram_wdata = ip_q + WORD_W'(2);
				end else begin
					ram_addr = ADDR_BITS'(ip_q + WORD_W'(1));
				end
			end
			ST_J_W1:  ram_addr = ADDR_BITS'(ip_q + WORD_W'(2));
			ST_J_W2:  ram_addr = ADDR_BITS'(f_q);
			ST_J_A:   ram_addr = ADDR_BITS'(w1_q);
			ST_J_B: begin
				alu_ctl.start = 1'b1;
				alu_ctl.fn    = FN_SUB;
			end
			ST_J_CMP: begin
				ram_we    = alu_sts.done;
				ram_wdata = take ? tgt_q : ip_q + WORD_W'(3);
			end
			ST_P_SRC: ram_addr = ADDR_BITS'(ip_q + WORD_W'(1));
			ST_G_SRC: ram_addr = ADDR_BITS'(f_q);
			ST_G_D: begin
				if (op_q == OP_MI) begin
					ram_addr  = ADDR_BITS'(f_q);
					ram_we    = 1'b1;
					ram_wdata = w1_q;
				end else begin
					ram_addr = ADDR_BITS'(w1_q);
				end
			end
			ST_G_S: begin
				ram_wdata = ram_rdata;
				if (op_q == OP_MV || op_q == OP_XG) begin
					ram_addr = ADDR_BITS'(f_q);
					ram_we   = 1'b1;
				end else if (op_q == OP_MD) begin
					ram_addr = ADDR_BITS'(ram_rdata);
				end
				alu_ctl.start = (op_q >= OP_AD) && (op_q <= OP_XOR);
				unique case (op_q)
					OP_SB:   alu_ctl.fn = FN_SUB;
					OP_AND:  alu_ctl.fn = FN_AND;
					OP_OR:   alu_ctl.fn = FN_OR;
					OP_XOR:  alu_ctl.fn = FN_XOR;
					default: alu_ctl.fn = FN_ADD;
				endcase
			end
			ST_G_DD: begin
				ram_addr  = ADDR_BITS'(f_q);
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_X_WR2: begin
				ram_addr  = ADDR_BITS'(w1_q);
				ram_we    = 1'b1;
				ram_wdata = d_q;
			end
			ST_ALU: begin
				ram_addr  = ADDR_BITS'(f_q);
				ram_we    = alu_sts.done;
				ram_wdata = alu_res;
			end
			ST_SHIFT: begin
				ram_addr  = ADDR_BITS'(f_q);
				ram_we    = (cnt_q == '0);
				ram_wdata = acc_q;
			end
			default: ;
		endcase
	end

	// sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_data_q <= '0;
						eptr_q    <= '0;
						eop_q     <= '0;
						unique case (req.kind)
							KIND_READ: state_q <= ST_RD_CAP;
							KIND_STEP: state_q <= ST_F_IP;
							default:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_RD_CAP: begin
					rd_data_q <= ram_rdata;
					state_q   <= ST_DONE;
				end
				ST_F_IP: begin
					ip_q    <= ram_rdata;
					state_q <= ST_F_W0;
				end
				ST_F_W0: begin
					eptr_q <= ip_q;
					eop_q  <= op_in;
					op_q   <= op_in;
					f_q    <= ram_rdata[FIELD_W-1:0];
					if (halt_q) begin
						state_q <= ST_DONE;
					end else if (op_in == OP_HLT) begin
						halt_q  <= 1'b1;
						state_q <= ST_DONE;
					end else if (op_in >= OP_JG) begin
						state_q <= ST_J_W1;
					end else begin
						state_q <= ST_P_SRC;
					end
				end
				ST_J_W1: begin
					w1_q    <= ram_rdata;
					state_q <= ST_J_W2;
				end
				ST_J_W2: begin
					tgt_q   <= ram_rdata;
					state_q <= ST_J_A;
				end
				ST_J_A: begin
					d_q     <= ram_rdata;
					state_q <= ST_J_B;
				end
				ST_J_B:   state_q <= ST_J_CMP;
				ST_J_CMP: if (alu_sts.done) state_q <= ST_DONE;
				ST_P_SRC: state_q <= ST_G_SRC;
				ST_G_SRC: begin
					w1_q    <= ram_rdata;
					state_q <= ST_G_D;
				end
				ST_G_D: begin
					d_q     <= ram_rdata;
					state_q <= (op_q == OP_MI) ? ST_DONE : ST_G_S;
				end
				ST_G_S: begin
					// shift count of 16 or more settles at once
					if (|ram_rdata[WORD_W-1:DIGIT_W]) begin
						acc_q <= (op_q == OP_SA && d_q[WORD_W-1]) ? '1 : '0;
						cnt_q <= '0;
					end else begin
						acc_q <= d_q;
						cnt_q <= ram_rdata[DIGIT_W-1:0];
					end
					priority if (op_q == OP_MV)  state_q <= ST_DONE;
					else if (op_q == OP_XG)      state_q <= ST_X_WR2;
					else if (op_q == OP_MD)      state_q <= ST_G_DD;
					else if (op_q >= OP_SR)      state_q <= ST_SHIFT;
					else                         state_q <= ST_ALU;
				end
				ST_G_DD:  state_q <= ST_DONE;
				ST_X_WR2: state_q <= ST_DONE;
				ST_ALU:   if (alu_sts.done) state_q <= ST_DONE;
				ST_SHIFT: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						unique case (op_q)
							OP_SL:   acc_q <= {acc_q[WORD_W-2:0], 1'b0};
							OP_SA:   acc_q <= {acc_q[WORD_W-1], acc_q[WORD_W-1:1]};
							default: acc_q <= {1'b0, acc_q[WORD_W-1:1]};
						endcase
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_data_q  <= rd_data_q;
						out_halt_q  <= halt_q;
						out_eptr_q  <= eptr_q;
						out_eop_q   <= eop_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.read_data        = out_data_q;
	assign rsp.halted           = out_halt_q;
	assign rsp.executed_pointer = out_eptr_q;
	assign rsp.executed_opcode  = out_eop_q;
endmodule

>>> src/mcs_checker.sv
// port-level checks of the step unit, bound to the top level
// depends on mcs_pkg and mem_to_mem_cpu_step_unit
module mcs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic [mcs_pkg::KIND_W-1:0]   req_kind,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [mcs_pkg::WORD_W-1:0]   rsp_read_data,
	input logic                         rsp_halted,
	input logic [mcs_pkg::WORD_W-1:0]   rsp_executed_pointer,
	input logic [mcs_pkg::OPC_W-1:0]    rsp_executed_opcode
);
	import mcs_pkg::*;

	logic              push, pop, seen_halt_q;
	logic [1:0]        cnt_q;
	logic [KIND_W-1:0] k0_q, k1_q;

	assign push = req_valid && req_ready;
	assign pop  = rsp_valid && rsp_ready;

	// count of requests still waiting for their response, and whether a halted response was seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			seen_halt_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop && rsp_halted) begin
				seen_halt_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd2) begin
				k0_q <= k1_q;
				k1_q <= req_kind;
			end else begin
				k0_q <= req_kind;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) k0_q <= req_kind;
			else               k1_q <= req_kind;
		end else if (pop) begin
			k0_q <= k1_q;
		end
	end

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cnt_q != 2'd0)
		else $error("response without a request");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seen_halt_q |-> rsp_halted)
		else $error("halt flag cleared");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cnt_q != 2'd0 && k0_q != KIND_READ |-> rsp_read_data == '0)
		else $error("read data on a non-read response");

	a_step_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cnt_q != 2'd0 && k0_q != KIND_STEP
		|-> rsp_executed_pointer == '0 && rsp_executed_opcode == '0)
		else $error("step fields on a non-step response");
endmodule

bind mem_to_mem_cpu_step_unit mcs_checker u_mcs_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.req_kind            (req.kind),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_read_data       (rsp.read_data),
	.rsp_halted          (rsp.halted),
	.rsp_executed_pointer(rsp.executed_pointer),
	.rsp_executed_opcode (rsp.executed_opcode)
);

>>> test/tb.sv
// testbench of mem_to_mem_cpu_step_unit: directed table, then programs with random content
// depends on mcs_pkg, mcs_req_if, mcs_rsp_if and the step unit itself
`timescale 1ns / 1ps

module tb;
	import mcs_pkg::*;

	typedef struct {
		word_t        read_data;
		logic         halted;
		word_t        executed_pointer;
		logic [3:0]   executed_opcode;
	} cpu_rsp_t;

	typedef struct {
		kind_t        kind;
		logic [14:0]  address;
		word_t        write_data;
		bit           typed;
		cpu_rsp_t     rsp;
	} table_row_t;

	logic clk;
	logic arst_n;

	mcs_req_if req_ch();
	mcs_rsp_if rsp_ch();

	mem_to_mem_cpu_step_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow machine state
	word_t    mem_img [MEM_WORDS];
	bit       written [MEM_WORDS];
	addr_t    written_list [$];
	bit       halt_img;

	cpu_rsp_t rsp_expected [$];
	int       errors;
	int       n_requests;
	int       n_responses;
	int       stall_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report(input string what, input int exp_v, input int got_v);
		$display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
		errors++;
	endtask

	function automatic word_t mem_rd(input word_t a);
		return mem_img[addr_t'(a)];
	endfunction

	function automatic void mem_wr(input word_t a, input word_t v);
		if (!written[addr_t'(a)])
			written_list.push_back(addr_t'(a));
		mem_img[addr_t'(a)] = v;
		written[addr_t'(a)] = 1'b1;
	endfunction

	function automatic word_t shifted(input op_t op, input word_t v, input word_t c);
		if (c >= 16)
			return (op == OP_SA && v[15]) ? 16'hFFFF : 16'h0000;
		case (op)
			OP_SR: return v >> c;
			OP_SL: return v << c;
			default: return word_t'($signed(v) >>> c);
		endcase
	endfunction

	function automatic void run_instr(input word_t ip, input word_t w0);
		op_t   op;
		word_t f;
		word_t src;
		word_t dv;
		word_t sv;
		word_t tgt;
		bit    take;
		op = op_t'(w0[15:12]);
		f = {4'b0, w0[11:0]};
		if (op == OP_HLT) begin
			halt_img = 1'b1;
		end else if (op >= OP_JG) begin
			src = mem_rd(ip + 16'd1);
			tgt = mem_rd(ip + 16'd2);
			dv = mem_rd(f);
			sv = mem_rd(src);
			take = (op == OP_JG) ? (dv > sv) : (op == OP_JL) ? (dv < sv) : (dv == sv);
			mem_wr(16'd0, take ? tgt : ip + 16'd3);
		end else begin
			// pointer goes first, so a field of 0 sees the new pointer
			mem_wr(16'd0, ip + 16'd2);
			src = mem_rd(ip + 16'd1);
			dv = mem_rd(f);
			case (op)
				OP_MV:  mem_wr(f, mem_rd(src));
				OP_XG: begin
					sv = mem_rd(src);
					mem_wr(f, sv);
					mem_wr(src, dv);
				end
				OP_AD:  mem_wr(f, dv + mem_rd(src));
				OP_SB:  mem_wr(f, dv - mem_rd(src));
				OP_AND: mem_wr(f, dv & mem_rd(src));
				OP_OR:  mem_wr(f, dv | mem_rd(src));
				OP_XOR: mem_wr(f, dv ^ mem_rd(src));
				OP_SR, OP_SL, OP_SA: mem_wr(f, shifted(op, dv, mem_rd(src)));
				OP_MI:  mem_wr(f, src);
				default: mem_wr(f, mem_rd(mem_rd(src)));
			endcase
		end
	endfunction

	function automatic cpu_rsp_t predict_cpu(input kind_t k, input logic [14:0] a,
		input word_t d);
		cpu_rsp_t r;
		word_t    ip;
		word_t    w0;
		r = '{default: 0};
		case (k)
			KIND_WRITE: mem_wr({1'b0, a}, d);
			KIND_READ:  r.read_data = mem_rd({1'b0, a});
			KIND_STEP: begin
				ip = mem_rd(16'd0);
				w0 = mem_rd(ip);
				r.executed_pointer = ip;
				r.executed_opcode = w0[15:12];
				if (!halt_img)
					run_instr(ip, w0);
			end
			default: ;
		endcase
		r.halted = halt_img;
		return r;
	endfunction

	// value of a word after the pointer write of a two-word instruction
	function automatic word_t after_ptr(input word_t a, input word_t np);
		return (addr_t'(a) == 0) ? np : mem_img[addr_t'(a)];
	endfunction

	// true when a step reads only words that hold a written value
	function automatic bit step_ok();
		word_t ip;
		word_t w0;
		word_t np;
		word_t src;
		word_t f;
		op_t   op;
		ip = mem_img[0];
		if (!written[0] || !written[addr_t'(ip)])
			return 0;
		if (halt_img)
			return 1;
		w0 = mem_img[addr_t'(ip)];
		op = op_t'(w0[15:12]);
		f = {4'b0, w0[11:0]};
		if (op == OP_HLT)
			return 1;
		if (op >= OP_JG)
			return written[addr_t'(ip + 16'd1)] && written[addr_t'(ip + 16'd2)]
				&& written[addr_t'(f)] && written[addr_t'(mem_img[addr_t'(ip + 16'd1)])];
		np = ip + 16'd2;
		if (!written[addr_t'(ip + 16'd1)] && addr_t'(ip + 16'd1) != 0)
			return 0;
		src = after_ptr(ip + 16'd1, np);
		if (!written[addr_t'(f)] && addr_t'(f) != 0)
			return 0;
		if (op == OP_MI)
			return 1;
		if (!written[addr_t'(src)] && addr_t'(src) != 0)
			return 0;
		if (op == OP_MD)
			return written[addr_t'(after_ptr(src, np))] || addr_t'(after_ptr(src, np)) == 0;
		return 1;
	endfunction

	task automatic send_request(input kind_t k, input logic [14:0] a, input word_t d,
		input bit typed, input cpu_rsp_t typed_rsp);
		int       gap;
		cpu_rsp_t r;
		gap = ((n_requests / 40) % 4 == 3) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.address <= a;
		req_ch.write_data <= d;
		do @(posedge clk); while (!req_ch.ready);
		r = predict_cpu(k, a, d);
		rsp_expected.push_back(typed ? typed_rsp : r);
		n_requests++;
	endtask

	task automatic send(input kind_t k, input logic [14:0] a, input word_t d);
		send_request(k, a, d, 1'b0, '{default: 0});
	endtask

	task automatic read_written();
		send(KIND_READ, written_list[$urandom_range(0, written_list.size() - 1)],
			word_t'($urandom));
	endtask

	task automatic step_or_read();
		if (step_ok())
			send(KIND_STEP, 15'($urandom), word_t'($urandom));
		else
			read_written();
	endtask

	function automatic word_t pick_addr();
		return ($urandom_range(0, 3) != 0) ? word_t'($urandom_range(1, 300)) : word_t'($urandom);
	endfunction

	// writes one instruction with its operands, points word 0 at it and runs it (a read instead if step_ok fails)
	task automatic program_step(input op_t op, input bit fixed_cnt, input word_t cnt);
		word_t       ip;
		word_t       src;
		word_t       fv;
		word_t       p;
		logic [11:0] f;
		ip = pick_addr();
		f = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 255));
		if ($urandom_range(0, 15) == 0)
			f = 12'd0;
		src = (op == OP_MI) ? word_t'($urandom) : pick_addr();
		fv = word_t'($urandom);
		send(KIND_WRITE, 15'd0, ip);
		send(KIND_WRITE, ip[14:0], {op, f});
		send(KIND_WRITE, 15'(ip + 16'd1), src);
		if (op >= OP_JG)
			send(KIND_WRITE, 15'(ip + 16'd2), word_t'($urandom));
		send(KIND_WRITE, {3'b0, f}, fv);
		if (op != OP_MI) begin
			if (fixed_cnt)
				send(KIND_WRITE, src[14:0], cnt);
			else if (op >= OP_SR && op <= OP_SA)
				send(KIND_WRITE, src[14:0], ($urandom_range(0, 3) != 0)
					? word_t'($urandom_range(0, 20)) : word_t'($urandom));
			else if (op >= OP_JG && $urandom_range(0, 2) == 0)
				send(KIND_WRITE, src[14:0], fv);
			else if (op == OP_MD) begin
				p = pick_addr();
				send(KIND_WRITE, src[14:0], p);
				send(KIND_WRITE, p[14:0], word_t'($urandom));
			end else
				send(KIND_WRITE, src[14:0], word_t'($urandom));
		end
		step_or_read();
		repeat ($urandom_range(0, 3)) begin
			if (step_ok())
				send(KIND_STEP, 15'($urandom), word_t'($urandom));
		end
	endtask

	// response side: random stall per response, then checks against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		cpu_rsp_t e;
		int       w;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_expected.size() == 0) begin
				$display("response with no request waiting");
				errors++;
			end else begin
				e = rsp_expected.pop_front();
				if (rsp_ch.read_data !== e.read_data)
					report("read_data", e.read_data, rsp_ch.read_data);
				if (rsp_ch.halted !== e.halted)
					report("halted", e.halted, rsp_ch.halted);
				if (rsp_ch.executed_pointer !== e.executed_pointer)
					report("executed_pointer", e.executed_pointer, rsp_ch.executed_pointer);
				if (rsp_ch.executed_opcode !== e.executed_opcode)
					report("executed_opcode", e.executed_opcode, rsp_ch.executed_opcode);
			end
			n_responses++;
			w = ((n_responses / 50) % 4 == 1) ? 0 : $urandom_range(0, 17);
			rsp_ch.ready <= (w == 0);
			stall_left <= w;
		end else if (!rsp_ch.ready) begin
			if (stall_left <= 1)
				rsp_ch.ready <= 1'b1;
			else
				stall_left <= stall_left - 1;
		end
	end

	initial begin
		#20ms;
		$display("mem_to_mem_cpu_step_unit regression: fail");
		$finish;
	end

	initial begin
		table_row_t rows [$];
		int         pick;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_WRITE;
		req_ch.address <= '0;
		req_ch.write_data <= '0;
		errors = 0;
		n_requests = 0;
		n_responses = 0;
		halt_img = 1'b0;
		foreach (mem_img[i]) begin
			mem_img[i] = '0;
			written[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{KIND_WRITE, 15'h7FFF, 16'hFFFF, 1, '{16'h0000, 0, 16'h0000, 4'h0}},
			'{KIND_WRITE, 15'h0000, 16'h0000, 1, '{16'h0000, 0, 16'h0000, 4'h0}},
			'{KIND_READ,  15'h7FFF, 16'h0000, 1, '{16'hFFFF, 0, 16'h0000, 4'h0}},
			'{KIND_READ,  15'h0000, 16'hFFFF, 1, '{16'h0000, 0, 16'h0000, 4'h0}},
			'{KIND_NONE,  15'h7FFF, 16'hFFFF, 1, '{16'h0000, 0, 16'h0000, 4'h0}},
			'{KIND_WRITE, 15'h4000, 16'hAAAA, 1, '{16'h0000, 0, 16'h0000, 4'h0}},
			'{KIND_WRITE, 15'h0001, 16'h4000, 1, '{16'h0000, 0, 16'h0000, 4'h0}},
			'{KIND_READ,  15'h4000, 16'h0000, 1, '{16'hAAAA, 0, 16'h0000, 4'h0}},
			'{KIND_READ,  15'h0001, 16'h0000, 1, '{16'h4000, 0, 16'h0000, 4'h0}},
			// move into word 0 overrides the new pointer
			'{KIND_STEP,  15'h7FFF, 16'hFFFF, 1, '{16'h0000, 0, 16'h0000, 4'h0}},
			'{KIND_READ,  15'h0000, 16'h0000, 1, '{16'hAAAA, 0, 16'h0000, 4'h0}},
			'{KIND_STEP,  15'h0000, 16'h0000, 0, '{16'h0000, 0, 16'h0000, 4'h0}}
		};
		foreach (rows[i]) begin
			if (rows[i].kind != KIND_STEP || step_ok())
				send_request(rows[i].kind, rows[i].address, rows[i].write_data,
					rows[i].typed, rows[i].rsp);
		end
		// each operation once, shifts also at the large-count edge
		for (int op = OP_MV; op <= OP_JQ; op++)
			program_step(op_t'(op), 1'b0, 16'd0);
		program_step(OP_SR, 1'b1, 16'd16);
		program_step(OP_SA, 1'b1, 16'd16);
		program_step(OP_SL, 1'b1, 16'd15);

		while (n_requests < 1250) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				program_step(op_t'($urandom_range(OP_MV, OP_JQ)), 1'b0, 16'd0);
			else if (pick < 75)
				send(KIND_WRITE, 15'($urandom), word_t'($urandom));
			else if (pick < 90)
				read_written();
			else if (pick < 95)
				send(KIND_NONE, 15'($urandom), word_t'($urandom));
			else
				step_or_read();
		end

		// halt is sticky until reset, so it comes last
		program_step(OP_HLT, 1'b0, 16'd0);
		repeat (20) begin
			pick = $urandom_range(0, 3);
			if (pick == 0)
				send(KIND_WRITE, 15'd0,
					word_t'(written_list[$urandom_range(0, written_list.size() - 1)]));
			else if (pick == 1)
				read_written();
			else if (pick == 2)
				send(KIND_NONE, 15'($urandom), word_t'($urandom));
			else
				step_or_read();
		end
		req_ch.valid <= 1'b0;

		while (rsp_expected.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("mem_to_mem_cpu_step_unit regression: pass");
		else
			$display("mem_to_mem_cpu_step_unit regression: fail");
		$finish;
	end

endmodule
